FILE: rtl/hm2tri_pkg.sv
// ----------------------------------------------------------------------------
// hm2tri_pkg
// Shared widths, register indexes, corner codes and the cell record type.
// ----------------------------------------------------------------------------
package hm2tri_pkg;

  localparam int SAMPLE_W  = 8;
  localparam int COORD_W   = 10;
  localparam int HQ_W      = 16;
  localparam int DIM_W     = 11;
  localparam int SLOT_W    = 3;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_MAX_WIDTH        = 1024;
  localparam int DEF_HEIGHT_FRAC_BITS = 11;
  localparam int DIM_CAP              = 1024;
  localparam int DIM_MIN              = 2;
  localparam int DIM_RESET            = 256;
  localparam int QUEUE_DEPTH          = 2;

  localparam longint HQ_DIV = 10;
  localparam longint HQ_MAX = (longint'(1) << HQ_W) - 1;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

  // corner codes: bit 0 = right, bit 1 = bottom
  localparam logic [1:0] C_TL = 2'd0;
  localparam logic [1:0] C_TR = 2'd1;
  localparam logic [1:0] C_BL = 2'd2;
  localparam logic [1:0] C_BR = 2'd3;

  localparam logic [SLOT_W-1:0] SLOT_LAST = 3'd5;

  typedef struct packed {
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic [SAMPLE_W-1:0] tl;
    logic [SAMPLE_W-1:0] tr;
    logic [SAMPLE_W-1:0] bl;
    logic [SAMPLE_W-1:0] br;
    logic                eof;
  } cell_t;

  // Vertex order of the two triangles; split when the diagonal corners differ.
  function automatic logic [1:0] corner_of(input logic split, input logic [SLOT_W-1:0] slot);
    logic [1:0] c;
    case (slot)
      3'd0:    c = split ? C_TR : C_TL;
      3'd1:    c = split ? C_TL : C_BL;
      3'd2:    c = split ? C_BR : C_TR;
      3'd3:    c = split ? C_BR : C_TR;
      3'd4:    c = split ? C_TL : C_BL;
      3'd5:    c = split ? C_BL : C_BR;
      default: c = C_TL;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/hm2tri_ifs.sv
// ----------------------------------------------------------------------------
// hm2tri channel interfaces
// Valid/ready channels for height samples in and vertices out.
// ----------------------------------------------------------------------------
interface hm2tri_in_if import hm2tri_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] height_sample;

  modport source (output valid, output height_sample, input ready);
  modport sink   (input valid, input height_sample, output ready);
endinterface

interface hm2tri_out_if import hm2tri_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pos_x;
  logic [COORD_W-1:0] pos_z;
  logic [HQ_W-1:0]    height_q;
  logic               tex_u;
  logic               tex_v;
  logic [SLOT_W-1:0]  corner_slot;
  logic               last_of_cell;
  logic               end_of_frame;

  modport source (output valid, output pos_x, output pos_z, output height_q,
                  output tex_u, output tex_v, output corner_slot,
                  output last_of_cell, output end_of_frame, input ready);
  modport sink   (input valid, input pos_x, input pos_z, input height_q,
                  input tex_u, input tex_v, input corner_slot,
                  input last_of_cell, input end_of_frame, output ready);
endinterface

FILE: rtl/hm2tri_front.sv
// ----------------------------------------------------------------------------
// hm2tri_front
// Accepts samples, tracks column and row, keeps the line buffer and forms
// one cell record for each sample that closes a grid cell.
// ----------------------------------------------------------------------------
module hm2tri_front import hm2tri_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata,
  hm2tri_in_if.sink            in_ch,
  output logic                 cell_valid,
  input  logic                 cell_ready,
  output cell_t                cell_rec
);

  localparam int WIDTH_CAP = (MAX_WIDTH < DIM_CAP) ? MAX_WIDTH : DIM_CAP;
  localparam int AW        = $clog2(MAX_WIDTH);

  function automatic logic [COORD_W-1:0] dim_last(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] cap);
    logic [DIM_W-1:0] c;
    if (v < DIM_W'(DIM_MIN)) begin
      c = DIM_W'(DIM_MIN);
    end else if (v > cap) begin
      c = cap;
    end else begin
      c = v;
    end
    return COORD_W'(c - 1'b1);
  endfunction

  logic [SAMPLE_W-1:0] line_mem [MAX_WIDTH];

  logic [COORD_W-1:0]  w_last_r, h_last_r;
  logic [COORD_W-1:0]  col_r, row_r, col_nxt, row_nxt;
  logic [SAMPLE_W-1:0] left_r, held_top_r;
  logic [SAMPLE_W-1:0] rd_data_r;
  logic                b_valid_r, b_cell_r, b_eof_r;
  logic [COORD_W-1:0]  b_col_r, b_row_r;
  logic [SAMPLE_W-1:0] b_left_r, b_s_r;

  logic          in_fire, b_adv, cfg_hit;
  logic [AW-1:0] addr;

  assign b_adv    = b_valid_r && (!b_cell_r || cell_ready);
  assign in_ch.ready = !b_valid_r || b_adv;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign addr     = AW'(col_r);
  assign cfg_hit  = cfg_we && (cfg_index == CFG_GRID_WIDTH || cfg_index == CFG_GRID_HEIGHT);

  always_comb begin
    col_nxt = col_r + 1'b1;
    row_nxt = row_r;
    if (col_r == w_last_r) begin
      col_nxt = '0;
      row_nxt = (row_r == h_last_r) ? '0 : row_r + 1'b1;
    end
  end

  // Read the previous row's sample and overwrite it in the same cycle.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      line_mem[addr] <= in_ch.height_sample;
      rd_data_r      <= line_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r   <= COORD_W'(DIM_RESET - 1);
      h_last_r   <= COORD_W'(DIM_RESET - 1);
      col_r      <= '0;
      row_r      <= '0;
      left_r     <= '0;
      held_top_r <= '0;
      b_valid_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        b_valid_r <= 1'b1;
        left_r    <= in_ch.height_sample;
        col_r     <= col_nxt;
        row_r     <= row_nxt;
      end else if (b_adv) begin
        b_valid_r <= 1'b0;
      end
      if (b_adv) begin
        held_top_r <= rd_data_r;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_GRID_WIDTH:  w_last_r <= dim_last(cfg_wdata, DIM_W'(WIDTH_CAP));
          CFG_GRID_HEIGHT: h_last_r <= dim_last(cfg_wdata, DIM_W'(DIM_CAP));
          default: ;
        endcase
      end
      // restart the frame on a write to the grid width or grid height register
      if (cfg_hit) begin
        col_r      <= '0;
        row_r      <= '0;
        left_r     <= '0;
        held_top_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_col_r  <= col_r;
      b_row_r  <= row_r;
      b_s_r    <= in_ch.height_sample;
      b_left_r <= left_r;
      b_cell_r <= (col_r != '0) && (row_r != '0);
      b_eof_r  <= (col_r == w_last_r) && (row_r == h_last_r);
    end
  end

  assign cell_valid   = b_valid_r && b_cell_r;
  assign cell_rec.col = b_col_r;
  assign cell_rec.row = b_row_r;
  assign cell_rec.tl  = held_top_r;
  assign cell_rec.tr  = rd_data_r;
  assign cell_rec.bl  = b_left_r;
  assign cell_rec.br  = b_s_r;
  assign cell_rec.eof = b_eof_r;

`ifndef ASSERT_OFF
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (col_r == '0 && row_r == '0))
    else $error("frame counters not cleared after register write");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && !b_adv) |=> (b_valid_r && $stable(b_col_r) && $stable(b_s_r)))
    else $error("stalled cell stage lost its item");
`endif

endmodule

FILE: rtl/hm2tri_queue.sv
// ----------------------------------------------------------------------------
// hm2tri_queue
// Short FIFO of cell records between the front and the vertex sequencer.
// ----------------------------------------------------------------------------
module hm2tri_queue import hm2tri_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  cell_t push_data,
  output logic  pop_valid,
  input  logic  pop_ready,
  output cell_t pop_data
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cell_t          slots_r [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;
  logic           do_push, do_pop;

  assign push_ready = (count_r != CW'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("cell queue overflow");
`endif

endmodule

FILE: rtl/hm2tri_back.sv
// ----------------------------------------------------------------------------
// hm2tri_back
// Walks each cell record through its six vertices, one per cycle while the output
// is ready, and holds each vertex in the output register until taken.
// ----------------------------------------------------------------------------
module hm2tri_back import hm2tri_pkg::*; #(
  parameter int HEIGHT_FRAC_BITS = DEF_HEIGHT_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cell_valid,
  output logic        cell_ready,
  input  cell_t       cell_rec,
  hm2tri_out_if.source out_ch
);

  logic [HQ_W-1:0] hq_lut [2**SAMPLE_W];

  // height quantization table, floor(s * 2^F / 10), saturated
  for (genvar gi = 0; gi < 2**SAMPLE_W; gi++) begin : g_hq
    localparam longint QV = (longint'(gi) * (longint'(1) << HEIGHT_FRAC_BITS)) / HQ_DIV;
    assign hq_lut[gi] = (QV > HQ_MAX) ? HQ_W'(HQ_MAX) : HQ_W'(QV);
  end

  logic [SLOT_W-1:0]   slot_r;
  logic                out_valid_r;
  logic [COORD_W-1:0]  pos_x_r, pos_z_r;
  logic [HQ_W-1:0]     height_q_r;
  logic                tex_u_r, tex_v_r, last_r, eof_r;
  logic [SLOT_W-1:0]   corner_slot_r;

  logic                load, split, right, bottom;
  logic [1:0]          corner;
  logic [SAMPLE_W-1:0] sample;

  assign load       = cell_valid && (!out_valid_r || out_ch.ready);
  assign cell_ready = load && (slot_r == SLOT_LAST);
  assign split      = (cell_rec.tl != cell_rec.br);
  assign corner     = corner_of(split, slot_r);
  assign right      = corner[0];
  assign bottom     = corner[1];

  always_comb begin
    case (corner)
      C_TL:    sample = cell_rec.tl;
      C_TR:    sample = cell_rec.tr;
      C_BL:    sample = cell_rec.bl;
      C_BR:    sample = cell_rec.br;
      default: sample = cell_rec.tl;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        slot_r      <= (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pos_x_r       <= right ? cell_rec.col : cell_rec.col - 1'b1;
      pos_z_r       <= bottom ? cell_rec.row : cell_rec.row - 1'b1;
      height_q_r    <= hq_lut[sample];
      tex_u_r       <= right;
      tex_v_r       <= bottom;
      corner_slot_r <= slot_r;
      last_r        <= (slot_r == SLOT_LAST);
      eof_r         <= (slot_r == SLOT_LAST) && cell_rec.eof;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pos_x        = pos_x_r;
  assign out_ch.pos_z        = pos_z_r;
  assign out_ch.height_q     = height_q_r;
  assign out_ch.tex_u        = tex_u_r;
  assign out_ch.tex_v        = tex_v_r;
  assign out_ch.corner_slot  = corner_slot_r;
  assign out_ch.last_of_cell = last_r;
  assign out_ch.end_of_frame = eof_r;

`ifndef ASSERT_OFF
  a_cell_held: assert property (@(posedge clk) disable iff (!rst_n)
    (slot_r != '0) |-> cell_valid)
    else $error("cell record left the queue before its sixth vertex");
`endif

endmodule

FILE: rtl/heightmap_to_triangle_list.sv
// A sample that closes a cell passes the front's cell stage, the cell queue and
// the output register. Vertices leave one per cycle while the output is ready;
// a closing sample yields six, and first-row and first-column samples yield none.
// A two-entry cell queue lets the front run ahead of the vertex sequencer.
// Reset: grid 256 x 256, counters at zero; the line buffer is not cleared and
// needs no clearing pass, since row 0 of each frame writes it before any read.
// ----------------------------------------------------------------------------
// heightmap_to_triangle_list
// Turns a raster stream of height samples into a triangle list, six vertices
// per grid cell.
// ----------------------------------------------------------------------------
module heightmap_to_triangle_list import hm2tri_pkg::*; #(
  parameter int MAX_WIDTH        = DEF_MAX_WIDTH,
  parameter int HEIGHT_FRAC_BITS = DEF_HEIGHT_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata,
  hm2tri_in_if.sink            in_ch,
  hm2tri_out_if.source         out_ch
);

  logic  f_valid, f_ready, q_valid, q_ready;
  cell_t f_cell, q_cell;

  hm2tri_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .cell_valid (f_valid),
    .cell_ready (f_ready),
    .cell_rec   (f_cell)
  );

  hm2tri_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cell),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cell)
  );

  hm2tri_back #(
    .HEIGHT_FRAC_BITS (HEIGHT_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cell_valid (q_valid),
    .cell_ready (q_ready),
    .cell_rec   (q_cell),
    .out_ch     (out_ch)
  );

endmodule
